### rtl/core/lpmf_pkg.sv
`default_nettype none
package lpmf_pkg;

  // Ring geometry
  localparam int BUF_BYTES = 1024;
  localparam int PTR_W     = $clog2(BUF_BYTES);
  localparam int CNT_W     = PTR_W + 1;
  localparam int LEN_W     = PTR_W;
  localparam int MAX_LEN   = BUF_BYTES - 2;

  // Message slot ring
  localparam int SLOT_W     = 8;
  localparam int SLOT_DEPTH = 1 << SLOT_W;
  localparam logic [SLOT_W-1:0] SLOTS_RESET = SLOT_W'(16);
  localparam logic [SLOT_W-1:0] SLOTS_MIN   = SLOT_W'(2);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int MLEN_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int OFFS_W   = 10;
  localparam int STATUS_W = 3;

  // Decoupling queues
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_BEGIN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DISCARD = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OFFSET   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SEQ      = 3'd4;

  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_DATA,
    OP_READ,
    OP_DISCARD
  } op_t;

  // Classified request handed from front to back
  typedef struct packed {
    op_t               op;
    logic              too_long;
    logic [MLEN_W-1:0] msg_len;
    logic [BYTE_W-1:0] data_byte;
    logic [OFFS_W-1:0] read_offset;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   read_byte;
    logic [LEN_W-1:0]    head_len;
    logic [CNT_W-1:0]    used_bytes;
    logic [SLOT_W-1:0]   msg_count;
    logic [SLOT_W-1:0]   dropped;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/lpmf_front.sv
`default_nettype none
module lpmf_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [lpmf_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [lpmf_pkg::MLEN_W-1:0] in_msg_len,
  input  wire logic [lpmf_pkg::BYTE_W-1:0] in_data_byte,
  input  wire logic [lpmf_pkg::OFFS_W-1:0] in_read_offset,
  input  wire logic                        deq,
  output logic                             cq_empty,
  output lpmf_pkg::cmd_t                   cq_head
);
  import lpmf_pkg::*;

  cmd_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_idx_r;
  logic [QPTR_W-1:0] rd_idx_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  cmd_t              cls;
  logic              do_push;
  logic              do_pop;

  // Classify the incoming request
  always_comb begin
    case (in_cmd)
      CMD_BEGIN:   cls.op = OP_BEGIN;
      CMD_DATA:    cls.op = OP_DATA;
      CMD_READ:    cls.op = OP_READ;
      CMD_DISCARD: cls.op = OP_DISCARD;
      default:     cls.op = OP_DISCARD;
    endcase
    cls.too_long    = (in_msg_len > MLEN_W'(MAX_LEN));
    cls.msg_len     = in_msg_len;
    cls.data_byte   = in_data_byte;
    cls.read_offset = in_read_offset;
  end

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign cq_empty = (cnt_r == '0);
  assign cq_head  = entry_r[rd_idx_r];
  assign do_push  = push && !full;
  assign do_pop   = deq && !cq_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_idx_r <= wr_idx_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_idx_r <= rd_idx_r + QPTR_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_idx_r] <= cls;
    end
  end

endmodule
`default_nettype wire

### rtl/core/lpmf_res_fifo.sv
`default_nettype none
module lpmf_res_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_push,
  input  wire lpmf_pkg::result_t res_in,
  output logic                   res_full,
  input  wire logic              pop,
  output logic                   empty,
  output lpmf_pkg::result_t      res_head
);
  import lpmf_pkg::*;

  result_t           entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_idx_r;
  logic [QPTR_W-1:0] rd_idx_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign res_full = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign res_head = entry_r[rd_idx_r];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_idx_r <= wr_idx_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_idx_r <= rd_idx_r + QPTR_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_idx_r] <= res_in;
    end
  end

endmodule
`default_nettype wire

### rtl/core/lpmf_back.sv
`default_nettype none
module lpmf_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [lpmf_pkg::SLOT_W-1:0] cfg_wdata,
  input  wire logic                        cq_empty,
  input  wire lpmf_pkg::cmd_t              cq_head,
  output logic                             deq,
  input  wire logic                        res_full,
  output logic                             res_push,
  output lpmf_pkg::result_t                res_out
);
  import lpmf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_DROPWAIT,
    S_PFXHI,
    S_RDWAIT,
    S_HLWAIT,
    S_RESP
  } state_t;

  // Byte ring and per-slot length store
  logic [BYTE_W-1:0] ring [BUF_BYTES];
  logic [LEN_W-1:0]  lmem [SLOT_DEPTH];
  logic [BYTE_W-1:0] ring_q;
  logic [LEN_W-1:0]  lmem_q;

  logic              ring_we;
  logic [PTR_W-1:0]  ring_waddr;
  logic [BYTE_W-1:0] ring_wdata;
  logic [PTR_W-1:0]  ring_raddr;
  logic              lmem_we;
  logic [SLOT_W-1:0] lmem_waddr;
  logic [SLOT_W-1:0] lmem_raddr;

  state_t              state_r, state_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]    free_r, free_nxt;
  logic [SLOT_W-1:0]   front_r, front_nxt;
  logic [SLOT_W-1:0]   rear_r, rear_nxt;
  logic [SLOT_W-1:0]   slots_r, slots_nxt;
  logic [LEN_W-1:0]    pend_r, pend_nxt;
  logic                open_r, open_nxt;
  logic [LEN_W-1:0]    open_len_r, open_len_nxt;
  logic [LEN_W-1:0]    head_len_r, head_len_nxt;
  logic [LEN_W-1:0]    cur_len_r, cur_len_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [BYTE_W-1:0]   rbyte_r, rbyte_nxt;
  logic [SLOT_W-1:0]   drops_r, drops_nxt;

  logic              q_empty;
  logic [SLOT_W-1:0] front_inc;
  logic [SLOT_W-1:0] rear_inc;
  logic              slot_full;
  logic              need_room;
  logic [CNT_W-1:0]  drop_total;
  logic [CNT_W:0]    free_add;
  logic [CNT_W-1:0]  free_after_drop;
  logic [CNT_W-1:0]  free_dec;
  logic [PTR_W-1:0]  drop_rd_ptr;
  logic [LEN_W-1:0]  pend_dec;
  logic [SLOT_W-1:0] slots_sat;
  logic [SLOT_W-1:0] count_diff;

  // Ring helpers
  assign q_empty   = (front_r == rear_r);
  assign front_inc = ((SLOT_W+1)'(front_r) + (SLOT_W+1)'(1) == (SLOT_W+1)'(slots_r)) ?
                     '0 : front_r + SLOT_W'(1);
  assign rear_inc  = ((SLOT_W+1)'(rear_r) + (SLOT_W+1)'(1) == (SLOT_W+1)'(slots_r)) ?
                     '0 : rear_r + SLOT_W'(1);
  assign slot_full = (rear_inc == front_r);
  assign need_room = (CNT_W'(cur_len_r) + CNT_W'(2) > free_r);

  // Head drop arithmetic
  assign drop_total      = CNT_W'(head_len_r) + CNT_W'(2);
  assign free_add        = (CNT_W+1)'(free_r) + (CNT_W+1)'(drop_total);
  assign free_after_drop = (free_add > (CNT_W+1)'(BUF_BYTES)) ?
                           CNT_W'(BUF_BYTES) : free_add[CNT_W-1:0];
  assign drop_rd_ptr     = rd_ptr_r + drop_total[PTR_W-1:0];
  assign free_dec        = (free_r != '0) ? free_r - CNT_W'(1) : free_r;
  assign pend_dec        = (pend_r != '0) ? pend_r - LEN_W'(1) : pend_r;
  assign slots_sat       = (cfg_wdata < SLOTS_MIN) ? SLOTS_MIN : cfg_wdata;

  // Next-state logic
  always_comb begin
    state_nxt    = state_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    free_nxt     = free_r;
    front_nxt    = front_r;
    rear_nxt     = rear_r;
    slots_nxt    = slots_r;
    pend_nxt     = pend_r;
    open_nxt     = open_r;
    open_len_nxt = open_len_r;
    head_len_nxt = head_len_r;
    cur_len_nxt  = cur_len_r;
    status_nxt   = status_r;
    rbyte_nxt    = rbyte_r;
    drops_nxt    = drops_r;
    ring_we      = 1'b0;
    ring_waddr   = wr_ptr_r;
    ring_wdata   = '0;
    ring_raddr   = rd_ptr_r + PTR_W'(cq_head.read_offset) + PTR_W'(2);
    lmem_we      = 1'b0;
    lmem_waddr   = rear_r;
    lmem_raddr   = front_inc;
    deq          = 1'b0;
    res_push     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!cq_empty && !res_full) begin
          deq         = 1'b1;
          cur_len_nxt = cq_head.msg_len[LEN_W-1:0];
          status_nxt  = ST_OK;
          rbyte_nxt   = '0;
          drops_nxt   = '0;
          state_nxt   = S_RESP;
          case (cq_head.op)
            OP_BEGIN: begin
              if (open_r) begin
                status_nxt = ST_SEQ;
              end else if (cq_head.too_long) begin
                status_nxt = ST_TOO_LONG;
              end else begin
                state_nxt = S_DROP;
              end
            end
            OP_DATA: begin
              if (!open_r) begin
                status_nxt = ST_SEQ;
              end else begin
                ring_we    = 1'b1;
                ring_wdata = cq_head.data_byte;
                wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
                free_nxt   = free_dec;
                pend_nxt   = pend_dec;
                // last byte closes the message
                if (pend_dec == '0) begin
                  rear_nxt = rear_inc;
                  open_nxt = 1'b0;
                  if (q_empty) begin
                    head_len_nxt = open_len_r;
                  end
                end
              end
            end
            OP_READ: begin
              if (q_empty) begin
                status_nxt = ST_EMPTY;
              end else if (LEN_W'(cq_head.read_offset) >= head_len_r) begin
                status_nxt = ST_OFFSET;
              end else begin
                state_nxt = S_RDWAIT;
              end
            end
            OP_DISCARD: begin
              if (q_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_ptr_nxt = drop_rd_ptr;
                free_nxt   = free_after_drop;
                front_nxt  = front_inc;
                if (front_inc != rear_r) begin
                  state_nxt = S_HLWAIT;
                end
              end
            end
            default: begin
              status_nxt = ST_SEQ;
            end
          endcase
        end
      end

      // Drop oldest messages until bytes and a slot are free, then write the low prefix byte
      S_DROP: begin
        if ((need_room || slot_full) && !q_empty) begin
          rd_ptr_nxt = drop_rd_ptr;
          free_nxt   = free_after_drop;
          front_nxt  = front_inc;
          drops_nxt  = drops_r + SLOT_W'(1);
          if (front_inc != rear_r) begin
            state_nxt = S_DROPWAIT;
          end
        end else begin
          ring_we    = 1'b1;
          ring_wdata = cur_len_r[BYTE_W-1:0];
          wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
          free_nxt   = free_dec;
          state_nxt  = S_PFXHI;
        end
      end

      S_DROPWAIT: begin
        head_len_nxt = lmem_q;
        state_nxt    = S_DROP;
      end

      // High prefix byte and slot length
      S_PFXHI: begin
        ring_we    = 1'b1;
        ring_wdata = BYTE_W'(cur_len_r >> BYTE_W);
        wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
        free_nxt   = free_dec;
        lmem_we    = 1'b1;
        if (cur_len_r == '0) begin
          rear_nxt = rear_inc;
          open_nxt = 1'b0;
          pend_nxt = '0;
          if (q_empty) begin
            head_len_nxt = '0;
          end
        end else begin
          open_nxt     = 1'b1;
          pend_nxt     = cur_len_r;
          open_len_nxt = cur_len_r;
        end
        state_nxt = S_RESP;
      end

      S_RDWAIT: begin
        rbyte_nxt = ring_q;
        state_nxt = S_RESP;
      end

      S_HLWAIT: begin
        head_len_nxt = lmem_q;
        state_nxt    = S_RESP;
      end

      S_RESP: begin
        res_push  = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Register write empties the queue
    if (cfg_we) begin
      slots_nxt  = slots_sat;
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      free_nxt   = CNT_W'(BUF_BYTES);
      front_nxt  = '0;
      rear_nxt   = '0;
      pend_nxt   = '0;
      open_nxt   = 1'b0;
      state_nxt  = S_IDLE;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      free_r     <= CNT_W'(BUF_BYTES);
      front_r    <= '0;
      rear_r     <= '0;
      slots_r    <= SLOTS_RESET;
      pend_r     <= '0;
      open_r     <= 1'b0;
      open_len_r <= '0;
      head_len_r <= '0;
      drops_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      free_r     <= free_nxt;
      front_r    <= front_nxt;
      rear_r     <= rear_nxt;
      slots_r    <= slots_nxt;
      pend_r     <= pend_nxt;
      open_r     <= open_nxt;
      open_len_r <= open_len_nxt;
      head_len_r <= head_len_nxt;
      drops_r    <= drops_nxt;
    end
    cur_len_r <= cur_len_nxt;
    status_r  <= status_nxt;
    rbyte_r   <= rbyte_nxt;
  end

  // Byte ring
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_waddr] <= ring_wdata;
    end
    ring_q <= ring[ring_raddr];
  end

  // Length per slot
  always_ff @(posedge clk) begin
    if (lmem_we) begin
      lmem[lmem_waddr] <= cur_len_r;
    end
    lmem_q <= lmem[lmem_raddr];
  end

  // Result assembly
  assign count_diff = rear_r - front_r + ((rear_r < front_r) ? slots_r : '0);

  always_comb begin
    res_out.status     = status_r;
    res_out.read_byte  = rbyte_r;
    res_out.head_len   = q_empty ? '0 : head_len_r;
    res_out.used_bytes = CNT_W'(BUF_BYTES) - free_r;
    res_out.msg_count  = count_diff;
    res_out.dropped    = drops_r;
  end

endmodule
`default_nettype wire

### rtl/core/length_prefixed_message_fifo_core.sv
// Length-prefixed message FIFO with drop-oldest admission.
// Input channel: drive in_* and raise push; a request is taken on a clock
// edge where push is high and full is low. A two-entry queue decodes and
// holds requests, so push may continue while the back end works.
// Result channel: while empty is low the oldest result sits on out_*; it is
// taken on an edge where pop is high. Two results are buffered; when the
// receiver stalls, the buffer fills, the back end stops taking requests and
// full rises once the request queue is also full.
// Config: cfg_we writes cfg_wdata as msg_slots (values below 2 become 2) and
// empties the message queue. Write only while the block is idle.
// Back end, one request at a time: a payload byte is written as it is
// taken; a read waits for the ring read data; a discard waits for the
// next head length when another message remains; a begin drops oldest
// messages one by one (reloading the head length while any remain), then
// writes the low and high prefix bytes. Every request, rejected ones too,
// ends by pushing its result, and only then does the back end take the next.
// Reset (rst_n low, synchronous): queue empty, msg_slots 16, both request
// and result queues flushed. Ring contents are left as they are.
`default_nettype none
module length_prefixed_message_fifo_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [lpmf_pkg::SLOT_W-1:0]   cfg_wdata,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [lpmf_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [lpmf_pkg::MLEN_W-1:0]   in_msg_len,
  input  wire logic [lpmf_pkg::BYTE_W-1:0]   in_data_byte,
  input  wire logic [lpmf_pkg::OFFS_W-1:0]   in_read_offset,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [lpmf_pkg::STATUS_W-1:0]      out_status,
  output logic [lpmf_pkg::BYTE_W-1:0]        out_read_byte,
  output logic [lpmf_pkg::LEN_W-1:0]         out_head_len,
  output logic [lpmf_pkg::CNT_W-1:0]         out_used_bytes,
  output logic [lpmf_pkg::SLOT_W-1:0]        out_msg_count,
  output logic [lpmf_pkg::SLOT_W-1:0]        out_dropped
);
  import lpmf_pkg::*;

  logic    cq_empty;
  cmd_t    cq_head;
  logic    deq;
  logic    res_full;
  logic    res_push;
  result_t res_out;
  result_t res_head;

  // Request intake and decode
  lpmf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_cmd         (in_cmd),
    .in_msg_len     (in_msg_len),
    .in_data_byte   (in_data_byte),
    .in_read_offset (in_read_offset),
    .deq            (deq),
    .cq_empty       (cq_empty),
    .cq_head        (cq_head)
  );

  // Ring and message bookkeeping
  lpmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cq_empty  (cq_empty),
    .cq_head   (cq_head),
    .deq       (deq),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_out   (res_out)
  );

  // Result buffering
  lpmf_res_fifo u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_in   (res_out),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .res_head (res_head)
  );

  assign out_status     = res_head.status;
  assign out_read_byte  = res_head.read_byte;
  assign out_head_len   = res_head.head_len;
  assign out_used_bytes = res_head.used_bytes;
  assign out_msg_count  = res_head.msg_count;
  assign out_dropped    = res_head.dropped;

endmodule
`default_nettype wire
